@@ sv/frl_pkg.sv @@
`default_nettype none

package frl_pkg;

    // Field widths
    localparam int TS_W       = 32;
    localparam int FPS_W      = 10;
    localparam int RATE_W     = 25;
    localparam int INTERVAL_W = 16;
    localparam int DELAY_W    = 10;

    // Defaults and fixed constants
    localparam int                WINDOW_DEF   = 100;
    localparam logic [FPS_W-1:0]  FPS_RESET    = 10'd60;
    localparam logic [FPS_W-1:0]  FPS_ONE      = 10'd1;
    localparam logic [FPS_W-1:0]  PERIOD_NUM   = 10'd1000;
    // 1000 frames/s in Q.8
    localparam int                RATE_SCALE   = 256000;
    localparam int                RATE_SCALE_W = 18;
    localparam logic [RATE_W-1:0] RATE_DEFAULT = 25'd15360;
    localparam logic [RATE_W-1:0] RATE_MAX     = 25'h1FFFFFF;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 16'hFFFF;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_WAIT,
        S_OUTPUT
    } t_frl_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic load_out;
    } t_frl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_frl_sts;

endpackage

`default_nettype wire

@@ sv/frl_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle
module frl_div
    import frl_pkg::*;
#(
    parameter int N_W = 25,
    parameter int D_W = 24
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_busy,
    output logic [N_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [D_W-1:0]   r_rem, n_rem;
    logic [D_W-1:0]   r_den, n_den;
    logic [N_W-1:0]   r_quo, n_quo;

    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    // One shift-subtract step
    always_comb begin
        trial = {r_rem, r_quo[N_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_W);
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            n_quo = {r_quo[N_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ sv/frl_ctrl.sv @@
`default_nettype none

// Sequencer: one frame at a time
module frl_ctrl
    import frl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_frl_sts i_sts,
    output t_frl_cmd      o_cmd
);

    t_frl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_OUTPUT;
                end
            end
            S_OUTPUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/frl_dp.sv @@
`default_nettype none

// Window store, running sum, dividers and output register
module frl_dp
    import frl_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_frl_cmd              i_cmd,
    output t_frl_sts                   o_sts,
    input  wire logic                  i_cfg_write,
    input  wire logic [FPS_W-1:0]      i_cfg_max_fps,
    input  wire logic [TS_W-1:0]       i_frame_start_ms,
    input  wire logic [TS_W-1:0]       i_frame_end_ms,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [RATE_W-1:0]          o_rate_q8,
    output logic [INTERVAL_W-1:0]      o_interval_ms,
    output logic [DELAY_W-1:0]         o_delay_ms
);

    localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W      = $clog2(WINDOW + 1);
    localparam int SUM_W      = INTERVAL_W + CNT_W;
    localparam int NUM_W      = $clog2(RATE_SCALE * WINDOW + 1);
    localparam int PROD_W     = CNT_W + RATE_SCALE_W;
    localparam int RATE_CMP_W = (NUM_W > RATE_W) ? NUM_W : RATE_W;

    localparam logic [CNT_W-1:0]        WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [RATE_SCALE_W-1:0] SCALE     = RATE_SCALE_W'(RATE_SCALE);

    // Interval window
    logic [INTERVAL_W-1:0] r_mem [WINDOW];
    logic [INTERVAL_W-1:0] r_rd_data;

    logic [FPS_W-1:0]      r_max_fps;
    logic [SUM_W-1:0]      r_sum;
    logic [SLOT_W-1:0]     r_slot;
    logic [CNT_W-1:0]      r_count;
    logic [TS_W-1:0]       r_last_end;
    logic                  r_seen;
    logic [TS_W-1:0]       r_frame;
    logic [INTERVAL_W-1:0] r_interval;

    logic                  r_out_valid;
    logic [RATE_W-1:0]     r_rate;
    logic [INTERVAL_W-1:0] r_out_interval;
    logic [DELAY_W-1:0]    r_delay;

    logic [TS_W-1:0]       diff;
    logic [INTERVAL_W-1:0] n_interval;
    logic                  full;
    logic [SUM_W-1:0]      n_sum;
    logic [PROD_W-1:0]     prod;
    logic [FPS_W-1:0]      fps_eff;
    logic                  rate_busy, per_busy;
    logic [NUM_W-1:0]      rate_quo;
    logic [FPS_W-1:0]      period;
    logic [RATE_CMP_W-1:0] rate_ext;
    logic [RATE_W-1:0]     n_rate;
    logic [DELAY_W-1:0]    n_delay;

    // Interval since previous end, saturated
    always_comb begin
        diff       = r_seen ? (i_frame_end_ms - r_last_end) : '0;
        n_interval = (diff > TS_W'(INTERVAL_MAX)) ? INTERVAL_MAX : diff[INTERVAL_W-1:0];
    end

    // Running sum update
    always_comb begin
        full  = (r_count == WIN_CNT);
        n_sum = full ? (r_sum - SUM_W'(r_rd_data) + SUM_W'(r_interval))
                     : (r_sum + SUM_W'(r_interval));
    end

    // Memory: read the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_slot];
        if (i_cmd.update) begin
            r_mem[r_slot] <= r_interval;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fps  <= FPS_RESET;
            r_sum      <= '0;
            r_slot     <= '0;
            r_count    <= '0;
            r_last_end <= '0;
            r_seen     <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_max_fps <= i_cfg_max_fps;
            end
            if (i_cmd.capture) begin
                r_last_end <= i_frame_end_ms;
                r_seen     <= 1'b1;
            end
            if (i_cmd.update) begin
                r_sum  <= n_sum;
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Per-frame payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_frame    <= i_frame_end_ms - i_frame_start_ms;
            r_interval <= n_interval;
        end
    end

    // Divider operands
    always_comb begin
        prod    = PROD_W'(r_count) * PROD_W'(SCALE);
        fps_eff = (r_max_fps == '0) ? FPS_ONE : r_max_fps;
    end

    frl_div #(
        .N_W (NUM_W),
        .D_W (SUM_W)
    ) u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (prod[NUM_W-1:0]),
        .i_den   (r_sum),
        .o_busy  (rate_busy),
        .o_quo   (rate_quo)
    );

    frl_div #(
        .N_W (FPS_W),
        .D_W (FPS_W)
    ) u_period_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (PERIOD_NUM),
        .i_den   (fps_eff),
        .o_busy  (per_busy),
        .o_quo   (period)
    );

    // Result words
    always_comb begin
        rate_ext = RATE_CMP_W'(rate_quo);
        if (r_sum == '0) begin
            n_rate = RATE_DEFAULT;
        end else if (rate_ext > RATE_CMP_W'(RATE_MAX)) begin
            n_rate = RATE_MAX;
        end else begin
            n_rate = rate_ext[RATE_W-1:0];
        end
        n_delay = (TS_W'(period) > r_frame) ? DELAY_W'(period - r_frame[FPS_W-1:0]) : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rate         <= n_rate;
            r_out_interval <= r_interval;
            r_delay        <= n_delay;
        end
    end

    always_comb begin
        o_sts.div_busy = rate_busy || per_busy;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_rate_q8     = r_rate;
    assign o_interval_ms = r_out_interval;
    assign o_delay_ms    = r_delay;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= WIN_CNT)
        else $error("fill count beyond window");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("write slot beyond window");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != WIN_CNT) |-> (CNT_W'(r_slot) == r_count))
        else $error("write slot out of step with fill count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("output word overwritten while held");
`endif

endmodule

`default_nettype wire

@@ sv/frame_rate_average_limiter.sv @@
`default_nettype none

// Frame rate averager and limiter. Each input word is one finished frame
// (start and end millisecond ticks). The block reports the interval since
// the previous frame end (0 for the first frame, saturated at 65535), the
// average rate over the last WINDOW intervals as 1000*count/sum in Q.8
// (60.0 when the sum is zero, capped at 2^25-1), and the delay
// max(0, floor(1000/max_fps) - (end - start)). One frame is handled at a
// time; the time per frame is set by the bit-serial rate divider, which
// runs alongside the period divider. A new frame is taken while the
// previous result still waits in the output register. max_fps may be
// written at any idle time; zero is treated as one. The interval store
// needs no clearing after reset.
module frame_rate_average_limiter
    import frl_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [FPS_W-1:0]      i_cfg_max_fps,
    // frame words in
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [TS_W-1:0]       i_frame_start_ms,
    input  wire logic [TS_W-1:0]       i_frame_end_ms,
    // result words out
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [RATE_W-1:0]          o_rate_q8,
    output logic [INTERVAL_W-1:0]      o_interval_ms,
    output logic [DELAY_W-1:0]         o_delay_ms
);

    t_frl_cmd cmd;
    t_frl_sts sts;

    assign o_cfg_ready = 1'b1;

    frl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    frl_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_write      (i_cfg_valid && o_cfg_ready),
        .i_cfg_max_fps    (i_cfg_max_fps),
        .i_frame_start_ms (i_frame_start_ms),
        .i_frame_end_ms   (i_frame_end_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rate_q8        (o_rate_q8),
        .o_interval_ms    (o_interval_ms),
        .o_delay_ms       (o_delay_ms)
    );

endmodule

`default_nettype wire
